// ===== src/mvm_pkg.sv =====
// Package for the matrix-vector multiply core: sizes, opcodes, register
// indexes, stage and result structs, and the effective-count helpers.
// No dependencies.
`default_nettype none

package mvm_pkg;

   localparam int MAX_COLS    = 64;
   localparam int MAX_ROWS    = 64;
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CFG_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int ELEM_W      = 32;
   localparam int ACC_W       = 64;
   localparam int ROW_NUM_W   = 6;
   localparam int RSP_QDEPTH  = 8;
   localparam int Q_PTR_W     = $clog2(RSP_QDEPTH);
   localparam int Q_CNT_W     = Q_PTR_W + 1;
   localparam int STAGE_CNT_W = 2;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_MATRIX = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd1;

   localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(MAX_COLS);
   localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(MAX_ROWS);

   typedef struct packed {
      logic                 last_col;
      logic [ROW_NUM_W-1:0] row_number;
      logic                 last_row;
   } mvm_tag_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] row_sum;
      logic [ROW_NUM_W-1:0]     row_number;
      logic                     last_row;
      logic                     overflow;
   } mvm_result_type;

   function automatic logic [COL_W:0] mvm_eff_cols(input logic [CFG_W-1:0] v);
      logic [COL_W:0] r;
      if (v == '0) begin
         r = (COL_W+1)'(1);
      end else if (32'(v) > MAX_COLS) begin
         r = (COL_W+1)'(MAX_COLS);
      end else begin
         r = (COL_W+1)'(v);
      end
      return r;
   endfunction

   function automatic logic [ROW_W:0] mvm_eff_rows(input logic [CFG_W-1:0] v);
      logic [ROW_W:0] r;
      if (v == '0) begin
         r = (ROW_W+1)'(1);
      end else if (32'(v) > MAX_ROWS) begin
         r = (ROW_W+1)'(MAX_ROWS);
      end else begin
         r = (ROW_W+1)'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/mvm_if.sv =====
// Channel interfaces of the matrix-vector multiply core: request and response.
// Depends on mvm_pkg.
`default_nettype none

interface mvm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic signed [mvm_pkg::ELEM_W-1:0]    element_value;

   modport source (output valid, output opcode, output element_value, input ready);
   modport sink   (input valid, input opcode, input element_value, output ready);
endinterface

interface mvm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mvm_pkg::ELEM_W-1:0]    row_sum;
   logic [mvm_pkg::ROW_NUM_W-1:0]        row_number;
   logic                                 last_row;
   logic                                 overflow;

   modport source (output valid, output row_sum, output row_number, output last_row,
                   output overflow, input ready);
   modport sink   (input valid, input row_sum, input row_number, input last_row,
                   input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/matrix_vector_multiply_core.sv =====
// Matrix-vector multiply core: sequencer, vector RAM, MAC stages, response queue.
// Depends on mvm_pkg, mvm_if, mvm_ram, mvm_mac and mvm_rsp_fifo.
//
// Usage:
//   req_chan carries one element per beat. Opcode load writes the next vector
//   entry (the load position wraps after cols_in_use entries); opcode matrix
//   is the next matrix element in row-major order. After the last column of a
//   row one beat leaves on rsp_chan with the rounded, saturated Q16.16 dot
//   product, the row index, a last-row mark and an overflow flag.
//   csr_* writes cols_in_use (index 0) or rows_in_use (index 1); write only
//   while no row is in progress and the pipeline has drained.
// Throughput: one beat per cycle while req_chan.ready is high, loads and matrix
//   elements mixed freely. The vector RAM gives one read and one write per cycle
//   and each beat uses one of them, so consecutive elements never collide on it.
// Path: a row result reaches rsp_chan after the beat that carries the row's last
//   element has passed the RAM read, multiply, accumulate and queue registers.
// Stall: the response queue holds 8 results. req_chan.ready drops when the
//   queue plus the elements still in the arithmetic stages could fill it, so
//   nothing is lost while the receiver holds rsp_chan.ready low.
// Reset: positions, accumulator and queue clear, registers return to 64;
//   the vector RAM is not cleared and must be loaded before use.
`default_nettype none

module matrix_vector_multiply_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mvm_req_if.sink                              req_chan,
   mvm_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_wr_en,
   input  wire logic [mvm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mvm_pkg::CFG_W-1:0]       csr_wr_data
);
   import mvm_pkg::*;

   // configuration
   logic [CFG_W-1:0] cols_ff, rows_ff;
   logic [COL_W:0]   ncols;
   logic [ROW_W:0]   nrows;

   // positions
   logic [COL_W-1:0] load_ff,  load_in;
   logic [COL_W-1:0] col_ff,   col_in;
   logic [ROW_W-1:0] row_ff,   row_in;
   logic [COL_W:0]   load_inc, col_inc;
   logic [ROW_W:0]   row_inc;
   logic             load_wrap, col_last, row_last;

   // handshake
   logic             accept, is_matrix, in_ready;

   // read stage, aligned with the RAM output
   logic             s1_valid_ff;
   mvm_tag_type      s1_tag_ff;
   logic signed [ELEM_W-1:0] s1_elem_ff;
   logic [ELEM_W-1:0]        vec_rd_data;

   // arithmetic and queue
   logic                     mac_valid;
   mvm_result_type           mac_result;
   logic [STAGE_CNT_W-1:0]   mac_busy;
   logic [STAGE_CNT_W:0]     inflight;
   mvm_result_type           q_head;
   logic                     q_valid;
   logic [Q_CNT_W-1:0]       q_count;

   assign ncols = mvm_eff_cols(cols_ff);
   assign nrows = mvm_eff_rows(rows_ff);

   // Reserve queue room for every element still in flight.
   assign inflight = (STAGE_CNT_W+1)'(mac_busy) + (STAGE_CNT_W+1)'(s1_valid_ff);
   assign in_ready = (32'(q_count) + 32'(inflight)) < RSP_QDEPTH;
   assign req_chan.ready = in_ready;

   assign accept    = req_chan.valid && in_ready;
   assign is_matrix = req_chan.opcode == OP_MATRIX;

   always_comb begin
      load_inc  = {1'b0, load_ff} + (COL_W+1)'(1);
      col_inc   = {1'b0, col_ff}  + (COL_W+1)'(1);
      row_inc   = {1'b0, row_ff}  + (ROW_W+1)'(1);
      load_wrap = load_inc >= ncols;
      col_last  = col_inc  >= ncols;
      row_last  = row_inc  >= nrows;
      load_in   = load_wrap ? '0 : load_inc[COL_W-1:0];
      col_in    = col_last  ? '0 : col_inc[COL_W-1:0];
      row_in    = row_last  ? '0 : row_inc[ROW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= COLS_RESET;
         rows_ff     <= ROWS_RESET;
         load_ff     <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COLS_IN_USE: cols_ff <= csr_wr_data;
               CSR_ROWS_IN_USE: rows_ff <= csr_wr_data;
               default: ;
            endcase
         end
         // advance the load pointer on a load, column and row on a matrix beat
         if (accept && !is_matrix) begin
            load_ff <= load_in;
         end
         if (accept && is_matrix) begin
            col_ff <= col_in;
            if (col_last) begin
               row_ff <= row_in;
            end
         end
         s1_valid_ff <= accept && is_matrix;
      end
      if (accept) begin
         s1_elem_ff          <= req_chan.element_value;
         s1_tag_ff.last_col   <= col_last;
         s1_tag_ff.row_number <= ROW_NUM_W'(row_ff);
         s1_tag_ff.last_row   <= row_last;
      end
   end

   // Loads write and matrix beats read on different cycles, and a write is
   // visible to a read at the next edge, so no forwarding is needed.
   mvm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (MAX_COLS)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (accept && !is_matrix),
      .wr_addr (load_ff),
      .wr_data (req_chan.element_value),
      .rd_en   (accept && is_matrix),
      .rd_addr (col_ff),
      .rd_data (vec_rd_data)
   );

   mvm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_tag     (s1_tag_ff),
      .in_element (s1_elem_ff),
      .vec_data   ($signed(vec_rd_data)),
      .out_valid  (mac_valid),
      .out_result (mac_result),
      .busy       (mac_busy)
   );

   mvm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mac_valid),
      .push_data (mac_result),
      .pop_ready (rsp_chan.ready),
      .pop_valid (q_valid),
      .pop_data  (q_head),
      .count     (q_count)
   );

   assign rsp_chan.valid      = q_valid;
   assign rsp_chan.row_sum    = q_head.row_sum;
   assign rsp_chan.row_number = q_head.row_number;
   assign rsp_chan.last_row   = q_head.last_row;
   assign rsp_chan.overflow   = q_head.overflow;

   // queue room is never overcommitted
   a_no_overcommit: assert property (@(posedge clock) disable iff (reset)
      (32'(q_count) + 32'(inflight)) <= RSP_QDEPTH)
      else $error("response queue overcommitted");

   // a load beat never enters the arithmetic stages
   a_load_no_mac: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_matrix) |=> !s1_valid_ff)
      else $error("load beat entered MAC stages");

   // the last column of a row yields a result after the read, product and accumulate stages
   a_row_end_result: assert property (@(posedge clock) disable iff (reset)
      (accept && is_matrix && col_last) |=> ##2 mac_valid)
      else $error("row result missing");

   // other matrix beats yield none
   a_mid_row_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && is_matrix && !col_last) |=> ##2 !mac_valid)
      else $error("spurious row result");

endmodule

`default_nettype wire

// ===== src/mvm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/mvm_mac.sv =====
// Multiply, saturating accumulate and Q16.16 rounding stages.
// Depends on mvm_pkg.
`default_nettype none

module mvm_mac (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire mvm_pkg::mvm_tag_type              in_tag,
   input  wire logic signed [mvm_pkg::ELEM_W-1:0] in_element,
   input  wire logic signed [mvm_pkg::ELEM_W-1:0] vec_data,
   output logic                                   out_valid,
   output mvm_pkg::mvm_result_type                out_result,
   output logic [mvm_pkg::STAGE_CNT_W-1:0]        busy
);
   import mvm_pkg::*;

   // product stage
   logic                     p_valid_ff;
   mvm_tag_type              p_tag_ff;
   logic signed [ACC_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]  prod_in;

   // accumulator and row-end stage
   logic signed [ACC_W-1:0]  acc_ff,   acc_in;
   logic                     rsat_ff,  rsat_in;
   logic                     a_valid_ff;
   mvm_tag_type              a_tag_ff;
   logic signed [ACC_W-1:0]  a_sum_ff;
   logic                     a_sat_ff;

   logic [ACC_W:0]           sum_wide;
   logic signed [ACC_W-1:0]  sum_sat;
   logic                     sum_ovf;

   logic signed [ACC_W-16:0] rounded;
   logic                     clip;

   assign prod_in = in_element * vec_data;

   always_comb begin
      sum_wide = {acc_ff[ACC_W-1], acc_ff} + {prod_ff[ACC_W-1], prod_ff};
      sum_ovf  = sum_wide[ACC_W] != sum_wide[ACC_W-1];
      if (sum_ovf) begin
         sum_sat = acc_ff[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end
      acc_in  = acc_ff;
      rsat_in = rsat_ff;
      if (p_valid_ff) begin
         if (p_tag_ff.last_col) begin
            acc_in  = '0;
            rsat_in = 1'b0;
         end else begin
            acc_in  = sum_sat;
            rsat_in = rsat_ff | sum_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         acc_ff     <= '0;
         rsat_ff    <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
         a_valid_ff <= p_valid_ff && p_tag_ff.last_col;
         acc_ff     <= acc_in;
         rsat_ff    <= rsat_in;
      end
      p_tag_ff <= in_tag;
      prod_ff  <= prod_in;
      a_tag_ff <= p_tag_ff;
      a_sum_ff <= sum_sat;
      a_sat_ff <= rsat_ff | sum_ovf;
   end

   // Q32.32 to Q16.16: round half up, then clip to the 32-bit range
   always_comb begin
      rounded = (ACC_W-15)'(a_sum_ff >>> 16) + (ACC_W-15)'({1'b0, a_sum_ff[15]});
      clip    = (rounded[ACC_W-16:ELEM_W-1] != '0) && (rounded[ACC_W-16:ELEM_W-1] != '1);
      out_result.row_number = a_tag_ff.row_number;
      out_result.last_row   = a_tag_ff.last_row;
      out_result.overflow   = a_sat_ff | clip;
      if (!clip) begin
         out_result.row_sum = rounded[ELEM_W-1:0];
      end else if (rounded[ACC_W-16]) begin
         out_result.row_sum = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         out_result.row_sum = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

   assign out_valid = a_valid_ff;
   assign busy      = STAGE_CNT_W'(p_valid_ff) + STAGE_CNT_W'(a_valid_ff);

endmodule

`default_nettype wire

// ===== src/mvm_rsp_fifo.sv =====
// Small response queue that decouples the arithmetic stages from the sink.
// Depends on mvm_pkg.
`default_nettype none

module mvm_rsp_fifo (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire mvm_pkg::mvm_result_type    push_data,
   input  wire logic                       pop_ready,
   output logic                            pop_valid,
   output mvm_pkg::mvm_result_type         pop_data,
   output logic [mvm_pkg::Q_CNT_W-1:0]     count
);
   import mvm_pkg::*;

   mvm_result_type     q_mem [RSP_QDEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff;
   logic               pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = count_ff != '0;
   assign pop_data  = q_mem[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + Q_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - Q_CNT_W'(1);
         end
      end
      if (push) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_matrix_vector_multiply_core.sv =====
// Self-checking testbench for matrix_vector_multiply_core: drives load and matrix beats,
// predicts each row's Q16.16 dot product and checks every response beat in order.
// Depends on mvm_pkg, mvm_if and the core RTL.

module tb_matrix_vector_multiply_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mvm_pkg::*;

   localparam int BEAT_TARGET  = 1050;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_OFF     = 150;

   localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
   localparam longint Q16_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Q16_MIN = 64'shFFFF_FFFF_8000_0000;

   // Idle patterns of the two channel ends.
   typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;
   // Magnitude classes of generated elements.
   typedef enum int {MAG_SMALL, MAG_MEDIUM, MAG_FULL, MAG_EDGE} mag_type;

   typedef struct {
      logic              opcode;
      logic [ELEM_W-1:0] value;
   } beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wr_data;

   mvm_req_if req_bus ();
   mvm_rsp_if rsp_bus ();

   matrix_vector_multiply_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow of the core: register values, vector store, positions, accumulator.
   logic [CFG_W-1:0]  cfg_cols = COLS_RESET;
   logic [CFG_W-1:0]  cfg_rows = ROWS_RESET;
   logic [ELEM_W-1:0] vector_mem [MAX_COLS];
   int                load_pos = 0;
   int                col_pos  = 0;
   int                row_pos  = 0;
   longint            row_acc  = 0;
   bit                row_sat  = 1'b0;

   beat_type       pending_beats [$];
   mvm_result_type expected_rows [$];

   bit beat_offered   = 1'b0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;

   int queued_beats  = 0;
   int loads_seen    = 0;
   int matrix_seen   = 0;
   int rows_seen     = 0;
   int overflow_seen = 0;
   int settings_run  = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp a register value to the count the core actually uses.
   function automatic int effective_count(input logic [CFG_W-1:0] v, input int max_count);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > max_count) begin
         return max_count;
      end
      return int'(v);
   endfunction

   // Advance the shadow by one accepted beat; queue the row result when a row closes.
   task automatic predict_row_result(input logic opcode, input logic [ELEM_W-1:0] value);
      int             n_cols;
      int             n_rows;
      int             pos;
      int             row;
      longint         product;
      longint         sum;
      longint         rounded;
      mvm_result_type row_out;
      n_cols = effective_count(cfg_cols, MAX_COLS);
      n_rows = effective_count(cfg_rows, MAX_ROWS);
      if (opcode == OP_LOAD) begin
         pos = load_pos % MAX_COLS;
         vector_mem[pos] = value;
         load_pos = (pos + 1 >= n_cols) ? 0 : pos + 1;
         return;
      end
      pos = col_pos % MAX_COLS;
      product = longint'($signed(value)) * longint'($signed(vector_mem[pos]));
      sum = row_acc + product;
      // Same-sign operands with a sign flip in the sum: clamp and flag the row.
      if (row_acc[63] == product[63] && sum[63] != row_acc[63]) begin
         row_acc = row_acc[63] ? ACC_MIN : ACC_MAX;
         row_sat = 1'b1;
      end else begin
         row_acc = sum;
      end
      if (pos + 1 < n_cols) begin
         col_pos = pos + 1;
         return;
      end
      // Q32.32 to Q16.16, round half up, then clamp to 32 bits.
      rounded = (row_acc >>> 16) + longint'(row_acc[15]);
      row_out.overflow = row_sat;
      if (rounded > Q16_MAX) begin
         row_out.row_sum  = 32'h7FFF_FFFF;
         row_out.overflow = 1'b1;
      end else if (rounded < Q16_MIN) begin
         row_out.row_sum  = 32'h8000_0000;
         row_out.overflow = 1'b1;
      end else begin
         row_out.row_sum = rounded[31:0];
      end
      row = row_pos % MAX_ROWS;
      row_out.row_number = ROW_NUM_W'(row);
      row_out.last_row   = (row + 1 >= n_rows);
      expected_rows.push_back(row_out);
      row_pos = (row + 1 >= n_rows) ? 0 : row + 1;
      col_pos = 0;
      row_acc = 0;
      row_sat = 1'b0;
   endtask

   function automatic mag_type pick_mag();
      int roll;
      roll = $urandom_range(99);
      if (roll < 35) begin
         return MAG_SMALL;
      end else if (roll < 60) begin
         return MAG_MEDIUM;
      end else if (roll < 85) begin
         return MAG_FULL;
      end
      return MAG_EDGE;
   endfunction

   function automatic logic [ELEM_W-1:0] random_element(input mag_type mag);
      logic [31:0] v;
      v = $urandom;
      case (mag)
         MAG_SMALL:  return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
         MAG_MEDIUM: return {{8{v[23]}}, v[23:0]};
         MAG_FULL:   return v;
         default: begin
            case ($urandom_range(0, 5))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               3:       return 32'hFFFF_FFFF;
               4:       return 32'h0001_0000;
               default: return 32'h0000_8000;
            endcase
         end
      endcase
   endfunction

   task automatic queue_beat(input logic opcode, input logic [ELEM_W-1:0] value);
      pending_beats.push_back('{opcode, value});
      queued_beats++;
   endtask

   // Queue whole rows at the current column count, with loads mixed in.
   task automatic queue_rows(input int n_rows);
      int      n_cols;
      mag_type row_mag;
      n_cols = effective_count(cfg_cols, MAX_COLS);
      for (int r = 0; r < n_rows; r++) begin
         row_mag = pick_mag();
         // Now and then reload the whole vector ahead of the row.
         if ($urandom_range(99) < 12) begin
            for (int c = 0; c < n_cols; c++) begin
               queue_beat(OP_LOAD, random_element(pick_mag()));
            end
         end
         for (int c = 0; c < n_cols; c++) begin
            if ($urandom_range(99) < 8) begin
               queue_beat(OP_LOAD, random_element(pick_mag()));
            end
            if ($urandom_range(99) < 85) begin
               queue_beat(OP_MATRIX, random_element(row_mag));
            end else begin
               queue_beat(OP_MATRIX, random_element(MAG_EDGE));
            end
         end
      end
   endtask

   // Wait until everything sent has been answered, then let the pipeline settle.
   task automatic wait_for_drain();
      while (pending_beats.size() != 0 || beat_offered || expected_rows.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      if (index == CSR_COLS_IN_USE) begin
         cfg_cols = data;
      end else begin
         cfg_rows = data;
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_SEND_IDLE:  begin send_idle_pct = 63; recv_stall_pct = 0;  end
         PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 63; end
         PACE_BOTH:       begin send_idle_pct = 8;  recv_stall_pct = 8;  end
         default:         begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // One register setting: program it on the idle core, run rows, drain.
   task automatic run_phase(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                            input int n_rows, input pace_type pace, input int hold);
      write_csr(CSR_COLS_IN_USE, cols);
      write_csr(CSR_ROWS_IN_USE, rows);
      settings_run++;
      set_pace(pace);
      hold_left = hold;
      queue_rows(n_rows);
      wait_for_drain();
   endtask

   // Driver: offer the next beat at the falling edge; hold it until accepted.
   always @(negedge clock) begin
      beat_type next_beat;
      if (!reset) begin
         if (!beat_offered && pending_beats.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_beat = pending_beats.pop_front();
            req_bus.opcode        <= next_beat.opcode;
            req_bus.element_value <= next_beat.value;
            beat_offered = 1'b1;
         end
         req_bus.valid <= beat_offered;
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Count down the long receiver hold-off.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
      end
   end

   // Monitor: feed accepted request beats to the shadow, check response beats in order.
   always @(posedge clock) begin
      mvm_result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_row_result(req_bus.opcode, req_bus.element_value);
            beat_offered = 1'b0;
            if (req_bus.opcode == OP_LOAD) begin
               loads_seen++;
            end else begin
               matrix_seen++;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rows_seen++;
            if (expected_rows.size() == 0) begin
               error_count++;
               $display("%0t: unexpected row result: expected none, actual sum %h row %0d",
                        $time, rsp_bus.row_sum, rsp_bus.row_number);
            end else begin
               want = expected_rows.pop_front();
               if (want.overflow) begin
                  overflow_seen++;
               end
               if (rsp_bus.row_sum !== want.row_sum) begin
                  error_count++;
                  $display("%0t: row_sum expected %h actual %h",
                           $time, want.row_sum, rsp_bus.row_sum);
               end
               if (rsp_bus.row_number !== want.row_number) begin
                  error_count++;
                  $display("%0t: row_number expected %0d actual %0d",
                           $time, want.row_number, rsp_bus.row_number);
               end
               if (rsp_bus.last_row !== want.last_row) begin
                  error_count++;
                  $display("%0t: last_row expected %b actual %b",
                           $time, want.last_row, rsp_bus.last_row);
               end
               if (rsp_bus.overflow !== want.overflow) begin
                  error_count++;
                  $display("%0t: overflow expected %b actual %b",
                           $time, want.overflow, rsp_bus.overflow);
               end
            end
         end
      end
   end

   // Guard against a hung core.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("tb_matrix_vector_multiply_core: errors");
         $finish;
      end
   end

   initial begin
      logic [CFG_W-1:0] cols;
      int               n_rows;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_COLS_IN_USE;
      csr_wr_data           = '0;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_LOAD;
      req_bus.element_value = '0;
      rsp_bus.ready         = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill every vector entry at the reset width so no read ever hits an unwritten one.
      for (int i = 0; i < MAX_COLS; i++) begin
         queue_beat(OP_LOAD, random_element(pick_mag()));
      end
      wait_for_drain();

      // Directed rows: two columns, three rows, extreme operands.
      write_csr(CSR_COLS_IN_USE, 7'd2);
      write_csr(CSR_ROWS_IN_USE, 7'd3);
      settings_run++;
      queue_beat(OP_LOAD, 32'h7FFF_FFFF);
      queue_beat(OP_LOAD, 32'h8000_0000);
      // Both products near the negative limit: output clamps low.
      queue_beat(OP_MATRIX, 32'h8000_0000);
      queue_beat(OP_MATRIX, 32'h7FFF_FFFF);
      // Opposite-sign products nearly cancel.
      queue_beat(OP_MATRIX, 32'h8000_0000);
      queue_beat(OP_MATRIX, 32'h8000_0000);
      // Two large positive products: output clamps high; last row, then wrap.
      queue_beat(OP_MATRIX, 32'h7FFF_FFFF);
      queue_beat(OP_MATRIX, 32'h8000_0000);
      // Reload with the most negative value: two products of 2^62 saturate.
      queue_beat(OP_LOAD, 32'h8000_0000);
      queue_beat(OP_LOAD, 32'h8000_0000);
      queue_beat(OP_MATRIX, 32'h8000_0000);
      queue_beat(OP_MATRIX, 32'h8000_0000);
      // Exact half ties: +0.5 rounds to one, -0.5 rounds to zero.
      queue_beat(OP_LOAD, 32'h0000_0001);
      queue_beat(OP_LOAD, 32'hFFFF_FFFF);
      queue_beat(OP_MATRIX, 32'h0000_8000);
      queue_beat(OP_MATRIX, 32'h0000_0000);
      queue_beat(OP_MATRIX, 32'h0000_8000);
      queue_beat(OP_MATRIX, 32'h0001_0000);
      // Load in the middle of a row.
      queue_beat(OP_MATRIX, 32'h0000_0000);
      queue_beat(OP_LOAD, 32'h0000_0005);
      queue_beat(OP_MATRIX, 32'hFFFF_FFFF);
      queue_beat(OP_MATRIX, 32'h7FFF_FFFF);
      queue_beat(OP_MATRIX, 32'h7FFF_FFFF);
      wait_for_drain();

      // Fixed settings: full width, single column and row, zero and oversize values
      // that clamp, a long receiver hold-off, and row counts that wrap.
      run_phase(7'd64,  7'd64,  3,  PACE_FREE,       0);
      run_phase(7'd1,   7'd1,   30, PACE_SEND_IDLE,  0);
      run_phase(7'd0,   7'd127, 70, PACE_RECV_STALL, 0);
      run_phase(7'd127, 7'd0,   2,  PACE_BOTH,       0);
      run_phase(7'd5,   7'd3,   24, PACE_FREE,       HOLD_OFF);
      run_phase(7'd33,  7'd2,   2,  PACE_SEND_IDLE,  0);
      run_phase(7'd2,   7'd64,  40, PACE_RECV_STALL, 0);
      run_phase(7'd9,   7'd100, 10, PACE_BOTH,       0);

      // Random settings, mostly narrow rows, until the beat budget is spent.
      while (queued_beats < BEAT_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1:    cols = CFG_W'($urandom_range(13, 64));
            2:       cols = ($urandom_range(0, 1) != 0) ? 7'd0 : CFG_W'($urandom_range(65, 127));
            default: cols = CFG_W'($urandom_range(1, 12));
         endcase
         n_rows = 60 / effective_count(cols, MAX_COLS);
         if (n_rows < 1) begin
            n_rows = 1;
         end
         run_phase(cols, CFG_W'($urandom_range(0, 127)), n_rows,
                   pace_type'($urandom_range(0, 3)), 0);
      end
      wait_for_drain();

      $display("run: %0d beats (%0d loads, %0d matrix elements) over %0d register settings",
               loads_seen + matrix_seen, loads_seen, matrix_seen, settings_run);
      $display("run: %0d row results checked, %0d flagged overflow, %0d mismatches",
               rows_seen, overflow_seen, error_count);
      if (error_count == 0) begin
         $display("tb_matrix_vector_multiply_core: clean");
      end else begin
         $display("tb_matrix_vector_multiply_core: errors");
      end
      $finish;
   end

endmodule
